[design/orq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_pkg
// Shared types, codes and defaults for the resizable overwrite ring queue.
// ----------------------------------------------------------------------------
package orq_pkg;

  localparam int DEF_MAX_DEPTH  = 64;
  localparam int DEF_DATA_WIDTH = 32;

  localparam int CFG_W   = 7;
  localparam int ACT_W   = 3;
  localparam int AMT_W   = 6;
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;

  localparam logic [CFG_W-1:0] INIT_CAPACITY = 7'd8;

  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LIST   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PRINT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_GROW   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLANK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [VALUE_W-1:0] item_value;
    logic [AMT_W-1:0]          grow_amount;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]         result_kind;
    logic signed [VALUE_W-1:0] result_value;
    logic                      last_result;
  } out_item_t;

  typedef struct packed {
    logic             accept;
    logic [ACT_W-1:0] op;
    logic             walk_step;
    logic             copy_step;
  } orq_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic issue_ok;
    logic walk_last;
    logic copy_done;
  } orq_status_t;

endpackage

[design/orq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_ctrl
// Request sequencer: takes a request, then walks (remove/list/print) or copies (grow) until done.
// ----------------------------------------------------------------------------
module orq_ctrl
  import orq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_stall,
  input  orq_status_t      status,
  output orq_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ACT_W-1:0] op_r, op_nxt;
  logic             can_take;

  assign can_take = (state_r == ST_IDLE) && !status.pipe_busy;
  assign in_stall = !can_take;

  always_comb begin
    cmd.accept    = in_valid && can_take;
    cmd.op        = (state_r == ST_IDLE) ? in_action : op_r;
    cmd.walk_step = (state_r == ST_WALK) && status.issue_ok;
    cmd.copy_step = (state_r == ST_COPY);
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          op_nxt = in_action;
          case (in_action) inside
            ACT_REMOVE, ACT_LIST, ACT_PRINT: state_nxt = ST_WALK;
            ACT_GROW:                        state_nxt = ST_COPY;
            default:                         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (cmd.walk_step && status.walk_last) state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        if (status.copy_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

[design/orq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_dp
// Slot memory, head/tail/capacity registers, walk and copy pointers, and the
// two-stage result pipeline (memory read stage and output register).
// ----------------------------------------------------------------------------
module orq_dp
  import orq_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  orq_cmd_t         cmd,
  output orq_status_t      status,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int CAP_W = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W = ((CAP_W > AMT_W) ? CAP_W : AMT_W) + 1;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CAP_W-1:0] r;
    if (v == '0) begin
      r = CAP_W'(1);
    end else if (v > CFG_W'(MAX_DEPTH)) begin
      r = CAP_W'(MAX_DEPTH);
    end else begin
      r = CAP_W'(v);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                input logic [CAP_W-1:0] n);
    logic [CAP_W-1:0] s;
    s = CAP_W'(x) + CAP_W'(1);
    return (s == n) ? '0 : IDX_W'(s);
  endfunction

  // slot storage
  logic [DATA_WIDTH-1:0] mem_r [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;

  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  src_r, src_nxt, dst_r, dst_nxt, pend_dst_r, pend_dst_nxt;
  logic [CAP_W-1:0]  cnt_r, cnt_nxt;
  logic              dir_up_r, dir_up_nxt, pend_r, pend_nxt;
  logic              p_valid_r, p_valid_nxt, p_last_r, p_last_nxt;
  logic [KIND_W-1:0] p_kind_r, p_kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic              advance;

  // walk step decode
  logic [KIND_W-1:0] w_kind;
  logic [IDX_W-1:0]  w_addr;
  logic              w_last, w_live;
  logic [IDX_W-1:0]  idx_inc, head_inc, tail_inc;

  // increase decode
  logic [SUM_W-1:0] g_sum;
  logic [CAP_W-1:0] g_new, g_applied;
  logic             g_wrapped, g_front;
  logic [CAP_W:0]   g_tail_sum;
  logic [IDX_W-1:0] g_tail_wrap, g_dst_front;

  assign idx_inc  = wrap_inc(idx_r, cap_r);
  assign head_inc = wrap_inc(head_r, cap_r);
  assign tail_inc = wrap_inc(tail_r, cap_r);

  assign w_live = (head_r <= tail_r) ? (idx_r >= head_r && idx_r < tail_r)
                                     : (idx_r < tail_r || idx_r >= head_r);

  always_comb begin
    w_kind = KIND_EMPTY;
    w_addr = idx_r;
    w_last = 1'b1;
    case (cmd.op)
      ACT_REMOVE: begin
        w_kind = (head_r == tail_r) ? KIND_EMPTY : KIND_VALUE;
        w_addr = head_r;
        w_last = 1'b1;
      end
      ACT_LIST: begin
        w_kind = (idx_r == tail_r) ? KIND_EMPTY : KIND_VALUE;
        w_last = (idx_r == tail_r) || (idx_inc == tail_r);
      end
      ACT_PRINT: begin
        w_kind = w_live ? KIND_VALUE : KIND_BLANK;
        w_last = (CAP_W'(idx_r) + CAP_W'(1)) == cap_r;
      end
      default: ;
    endcase
  end

  assign g_sum       = SUM_W'(cap_r) + SUM_W'(in_item.grow_amount);
  assign g_new       = (g_sum > SUM_W'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH) : g_sum[CAP_W-1:0];
  assign g_applied   = g_new - cap_r;
  assign g_wrapped   = head_r > tail_r;
  assign g_front     = (cap_r - CAP_W'(head_r)) >= CAP_W'(tail_r);
  assign g_tail_sum  = (CAP_W+1)'(tail_r) + (CAP_W+1)'(cap_r);
  assign g_tail_wrap = (g_tail_sum >= (CAP_W+1)'(g_new))
                     ? IDX_W'(g_tail_sum - (CAP_W+1)'(g_new)) : IDX_W'(g_tail_sum);
  assign g_dst_front = (cap_r == g_new) ? '0 : IDX_W'(cap_r);

  assign advance = p_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    cap_nxt       = cap_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    cnt_nxt       = cnt_r;
    dir_up_nxt    = dir_up_r;
    pend_nxt      = 1'b0;
    pend_dst_nxt  = pend_dst_r;
    p_valid_nxt   = advance ? 1'b0 : p_valid_r;
    p_kind_nxt    = p_kind_r;
    p_last_nxt    = p_last_r;
    mem_re        = 1'b0;
    mem_ra        = w_addr;
    mem_we        = pend_r;
    mem_wa        = pend_dst_r;
    mem_wd        = rdata_r;

    if (cfg_wr_en) begin
      cap_nxt  = clamp_cap(cfg_wr_data);
      head_nxt = '0;
      tail_nxt = '0;
    end

    if (cmd.accept) begin
      case (cmd.op)
        ACT_ADD: begin
          if (tail_inc == head_r) head_nxt = head_inc;
          tail_nxt = tail_inc;
          mem_we   = 1'b1;
          mem_wa   = tail_r;
          mem_wd   = DATA_WIDTH'(64'($unsigned(in_item.item_value)));
        end
        ACT_LIST:  idx_nxt = head_r;
        ACT_PRINT: idx_nxt = '0;
        ACT_GROW: begin
          cap_nxt = g_new;
          cnt_nxt = '0;
          if (g_wrapped) begin
            if (g_front) begin
              cnt_nxt    = CAP_W'(tail_r);
              src_nxt    = '0;
              dst_nxt    = g_dst_front;
              dir_up_nxt = 1'b1;
              tail_nxt   = g_tail_wrap;
            end else begin
              cnt_nxt    = cap_r - CAP_W'(head_r);
              src_nxt    = IDX_W'(cap_r - CAP_W'(1));
              dst_nxt    = IDX_W'(g_new - CAP_W'(1));
              dir_up_nxt = 1'b0;
              head_nxt   = IDX_W'(CAP_W'(head_r) + g_applied);
            end
          end
        end
        default: ;
      endcase
    end

    if (cmd.walk_step) begin
      p_valid_nxt = 1'b1;
      p_kind_nxt  = w_kind;
      p_last_nxt  = w_last;
      mem_re      = (w_kind == KIND_VALUE);
      idx_nxt     = idx_inc;
      if (cmd.op == ACT_REMOVE && w_kind == KIND_VALUE) head_nxt = head_inc;
    end

    if (cmd.copy_step && cnt_r != '0) begin
      mem_re       = 1'b1;
      mem_ra       = src_r;
      pend_nxt     = 1'b1;
      pend_dst_nxt = dst_r;
      cnt_nxt      = cnt_r - CAP_W'(1);
      if (dir_up_r) begin
        src_nxt = src_r + IDX_W'(1);
        dst_nxt = wrap_inc(dst_r, cap_r);
      end else begin
        src_nxt = src_r - IDX_W'(1);
        dst_nxt = dst_r - IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (advance) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.result_kind  = p_kind_r;
      out_item_nxt.result_value = (p_kind_r == KIND_VALUE) ? 32'(64'(rdata_r)) : '0;
      out_item_nxt.last_result  = p_last_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    status.pipe_busy = p_valid_r;
    status.issue_ok  = !p_valid_r || advance;
    status.walk_last = w_last;
    status.copy_done = (cnt_r == '0) && !pend_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= clamp_cap(INIT_CAPACITY);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    dir_up_r   <= dir_up_nxt;
    pend_dst_r <= pend_dst_nxt;
    p_kind_r   <= p_kind_nxt;
    p_last_r   <= p_last_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

[design/overwrite_ring_queue_resizable.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_queue_resizable
// Resizable ring queue with overwrite on full, listing, slot dump and growth.
// ----------------------------------------------------------------------------
// add: stored when the request is taken; remove/list/print: one slot read per cycle
// while the output is not stalled, results passing read stage and output register in order
// increase: capacity set when taken, then a moved wrapped segment is copied slot by slot
// a request is taken once the sequencer is idle and the read stage is empty
// synchronous active-low reset: capacity 8 (clamped), queue empty, no results
module overwrite_ring_queue_resizable
  import orq_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  orq_cmd_t    cmd;
  orq_status_t status;

  orq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_item.action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  orq_dp #(
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

[design/orq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orq_checker
// Port-level checks for the ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module orq_checker
  import orq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind != KIND_VALUE |-> out_item.result_value == '0)
    else $error("marker carries a value");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == KIND_EMPTY |-> out_item.last_result)
    else $error("empty marker not final");

  a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_stall))
    else $error("input stall unknown");

endmodule

bind overwrite_ring_queue_resizable orq_checker u_orq_checker (.*);

[tb/sv/tb_overwrite_ring_queue_resizable.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwrite_ring_queue_resizable
// Self-checking bench for the resizable overwrite ring queue. A short table of
// directed requests runs first, followed by random request streams under
// several capacity settings and idling profiles. Every result is checked
// field by field against typed table rows or an in-bench ring predictor.
// ----------------------------------------------------------------------------
module tb_overwrite_ring_queue_resizable;
  import orq_pkg::*;

  localparam int DEPTH       = DEF_MAX_DEPTH;
  localparam int SETTLE      = DEF_MAX_DEPTH + 16;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_ITEMS   = 36;
  localparam int N_SEGS      = 6;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    cap;
    in_item_t            req;
    int                  n_typed;
    logic [KIND_W-1:0]   t_kind;
    logic [VALUE_W-1:0]  t_value;
  } plan_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  // predictor state
  logic [VALUE_W-1:0] q_slot [DEPTH];
  int                 q_head;
  int                 q_tail;
  int                 q_cap;

  out_item_t step_out[$];
  out_item_t due_results[$];
  plan_row_t plan[$];

  int  tx_pct;
  int  rx_pct;
  bit  rx_hold_req;
  int  rx_hold_left;
  int  idle_run;
  int  n_items;
  int  n_checked;
  int  n_cfg;
  int  n_errors;

  overwrite_ring_queue_resizable dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int clamp_capacity(input logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > DEPTH) return DEPTH;
    return int'(v);
  endfunction

  function automatic void note(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    out_item_t o;
    o.result_kind  = k;
    o.result_value = v;
    o.last_result  = 1'b0;
    step_out.push_back(o);
  endfunction

  task automatic ring_apply(input in_item_t r);
    int        i;
    int        old_n;
    int        new_n;
    int        applied;
    bit        live;
    out_item_t o;
    step_out.delete();
    case (r.action)
      ACT_ADD: begin
        if ((q_tail + 1) % q_cap == q_head) q_head = (q_head + 1) % q_cap;
        q_slot[q_tail] = r.item_value;
        q_tail = (q_tail + 1) % q_cap;
      end
      ACT_REMOVE: begin
        if (q_head == q_tail) begin
          note(KIND_EMPTY, '0);
        end else begin
          note(KIND_VALUE, q_slot[q_head]);
          q_head = (q_head + 1) % q_cap;
        end
      end
      ACT_LIST: begin
        if (q_head == q_tail) begin
          note(KIND_EMPTY, '0);
        end else begin
          for (i = q_head; i != q_tail && step_out.size() < DEPTH; i = (i + 1) % q_cap)
            note(KIND_VALUE, q_slot[i]);
        end
      end
      ACT_PRINT: begin
        for (i = 0; i < q_cap; i++) begin
          if (q_head <= q_tail) live = (i >= q_head) && (i < q_tail);
          else live = (i < q_tail) || (i >= q_head);
          if (live) note(KIND_VALUE, q_slot[i]);
          else note(KIND_BLANK, '0);
        end
      end
      ACT_GROW: begin
        old_n = q_cap;
        new_n = old_n + int'(r.grow_amount);
        if (new_n > DEPTH) new_n = DEPTH;
        applied = new_n - old_n;
        q_cap = new_n;
        if (q_head > q_tail) begin
          if (old_n - q_head >= q_tail) begin
            // wrapped front segment moves past the old end
            for (i = 0; i < q_tail; i++) q_slot[(old_n + i) % new_n] = q_slot[i];
            q_tail = (q_tail + old_n) % new_n;
          end else begin
            // head segment (head to old end) shifts up by the growth actually applied
            for (i = old_n; i > q_head; i--) q_slot[(i - 1 + applied) % DEPTH] = q_slot[i - 1];
            q_head = (q_head + applied) % new_n;
          end
        end
      end
      default: ;
    endcase
    if (step_out.size() > 0) begin
      o = step_out.pop_back();
      o.last_result = 1'b1;
      step_out.push_back(o);
    end
  endtask

  function automatic plan_row_t op_row(input logic [ACT_W-1:0] a, input logic [VALUE_W-1:0] v,
                                       input logic [AMT_W-1:0] g, input int n,
                                       input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] tv);
    plan_row_t p;
    p.is_cfg            = 1'b0;
    p.cap               = '0;
    p.req.action        = a;
    p.req.item_value    = v;
    p.req.grow_amount   = g;
    p.n_typed           = n;
    p.t_kind            = k;
    p.t_value           = tv;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_W-1:0] c);
    plan_row_t p;
    p = op_row(ACT_ADD, '0, '0, 0, KIND_VALUE, '0);
    p.is_cfg = 1'b1;
    p.cap    = c;
    return p;
  endfunction

  function automatic in_item_t random_req();
    in_item_t r;
    int       p;
    p = $urandom_range(0, 99);
    if (p < 45) r.action = ACT_ADD;
    else if (p < 63) r.action = ACT_REMOVE;
    else if (p < 71) r.action = ACT_LIST;
    else if (p < 77) r.action = ACT_PRINT;
    else if (p < 92) r.action = ACT_GROW;
    else r.action = ACT_W'($urandom_range(5, 7));
    p = $urandom_range(0, 99);
    if (p < 5) r.item_value = 32'h8000_0000;
    else if (p < 10) r.item_value = 32'h7FFF_FFFF;
    else r.item_value = $urandom;
    if ($urandom_range(0, 99) < 80) r.grow_amount = AMT_W'($urandom_range(0, 3));
    else r.grow_amount = AMT_W'($urandom_range(0, 63));
    return r;
  endfunction

  task automatic send_req(input in_item_t r);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    q_cap  = clamp_capacity(c);
    q_head = 0;
    q_tail = 0;
    n_cfg++;
  endtask

  task automatic run_row(input plan_row_t p);
    int i;
    out_item_t o;
    if (p.is_cfg) begin
      write_capacity(p.cap);
    end else begin
      send_req(p.req);
      ring_apply(p.req);
      if (p.n_typed > 0) begin
        for (i = 0; i < p.n_typed; i++) begin
          o.result_kind  = p.t_kind;
          o.result_value = p.t_value;
          o.last_result  = (i == p.n_typed - 1);
          due_results.push_back(o);
        end
      end else begin
        foreach (step_out[i]) due_results.push_back(step_out[i]);
      end
    end
  endtask

  // receiver: random stall plus a long hold-off requested by the stimulus
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got kind %0d value %0h last %0d",
                 $time, out_item.result_kind, out_item.result_value, out_item.last_result);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        if (out_item.result_kind !== want.result_kind ||
            out_item.result_value !== want.result_value ||
            out_item.last_result !== want.last_result) begin
          n_errors++;
          $display({"%0t: result mismatch, expected kind %0d value %0h last %0d, ",
                    "got kind %0d value %0h last %0d"},
                   $time, want.result_kind, want.result_value, want.last_result,
                   out_item.result_kind, out_item.result_value, out_item.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid && !out_stall) || cfg_wr_en) idle_run = 0;
    else idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("%0t: watchdog, no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int        seg;
    int        cnt;
    in_item_t  r;
    logic [CFG_W-1:0] seg_cap [N_SEGS];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    rx_hold_req  = 1'b0;
    rx_hold_left = 0;
    idle_run     = 0;
    tx_pct       = 0;
    rx_pct       = 0;
    n_items      = 0;
    n_checked    = 0;
    n_cfg        = 0;
    n_errors     = 0;
    foreach (q_slot[i]) q_slot[i] = '0;
    q_cap  = clamp_capacity(INIT_CAPACITY);
    q_head = 0;
    q_tail = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    plan.push_back(op_row(ACT_PRINT,  '0, '0, 8, KIND_BLANK, '0));
    plan.push_back(op_row(ACT_REMOVE, '0, '0, 1, KIND_EMPTY, '0));
    plan.push_back(op_row(ACT_LIST,   '0, '0, 1, KIND_EMPTY, '0));
    plan.push_back(op_row(ACT_ADD,    32'h8000_0000, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_REMOVE, '0, '0, 1, KIND_VALUE, 32'h8000_0000));
    plan.push_back(op_row(ACT_ADD,    32'h7FFF_FFFF, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'hFFFF_FFFF, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_GROW,   '0, 6'd0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'h0000_0001, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'h5555_5555, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'hAAAA_AAAA, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'h0F0F_0F0F, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'hF0F0_F0F0, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_ADD,    32'h1234_5678, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_LIST,   '0, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_REMOVE, '0, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_PRINT,  '0, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_GROW,   '0, 6'd2, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_GROW,   '0, 6'd63, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_LIST,   '0, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(3'd5,       32'hDEAD_BEEF, 6'd5, 0, KIND_VALUE, '0));
    plan.push_back(op_row(3'd7,       32'hFFFF_FFFF, 6'd63, 0, KIND_VALUE, '0));
    plan.push_back(cfg_row(7'd0));
    plan.push_back(op_row(ACT_ADD,    32'h0000_00A5, '0, 0, KIND_VALUE, '0));
    plan.push_back(op_row(ACT_REMOVE, '0, '0, 1, KIND_EMPTY, '0));
    plan.push_back(op_row(ACT_PRINT,  '0, '0, 1, KIND_BLANK, '0));
    plan.push_back(cfg_row(7'd127));
    plan.push_back(op_row(ACT_PRINT,  '0, '0, 64, KIND_BLANK, '0));

    tx_pct = 10;
    rx_pct = 30;
    foreach (plan[i]) run_row(plan[i]);

    // random streams, one capacity setting per segment
    seg_cap[0] = 7'd3;
    seg_cap[1] = 7'd64;
    seg_cap[2] = 7'd0;
    seg_cap[3] = 7'd127;
    seg_cap[4] = 7'd1;
    seg_cap[5] = CFG_W'($urandom_range(2, 12));
    for (seg = 0; seg < N_SEGS; seg++) begin
      write_capacity(seg_cap[seg]);
      case (seg / 2)
        0: begin
          tx_pct = 18;
          rx_pct = 61;
        end
        1: begin
          tx_pct = 61;
          rx_pct = 18;
        end
        default: begin
          tx_pct = 0;
          rx_pct = 0;
        end
      endcase
      cnt = 0;
      while (cnt < SEG_ITEMS) begin
        if (seg == 0 && cnt == 10) rx_hold_req = 1'b1;
        if (seg == 3 && cnt == 20) drain();
        r = random_req();
        send_req(r);
        ring_apply(r);
        foreach (step_out[i]) due_results.push_back(step_out[i]);
        if (r.action <= ACT_GROW) cnt++;
      end
    end

    drain();
    $display("covered %0d requests over %0d capacity writes, %0d results checked",
             n_items, n_cfg, n_checked);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[overwrite_ring_queue_resizable.f]
design/orq_pkg.sv
design/orq_ctrl.sv
design/orq_dp.sv
design/overwrite_ring_queue_resizable.sv
design/orq_checker.sv
tb/sv/tb_overwrite_ring_queue_resizable.sv
